### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/hfsw_pkg.sv
// ----------------------------------------------------------------------------
// HLL shallow water flux package
// Shared types, constants and saturating helpers.
// ----------------------------------------------------------------------------
package hfsw_pkg;

  localparam int VAL_W      = 64;
  localparam int MAG_W      = 62;
  localparam int MUL_LAT    = 4;
  localparam int GRAVITY_W  = 22;
  localparam int DRY_TOL_W  = 16;
  localparam int DEPTH_W    = 31;
  localparam int DISCH_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam logic [VAL_W-1:0] LIM_MAG = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam val_t LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam val_t NLIM = -64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [GRAVITY_W-1:0] GRAVITY_RST = 22'd642689;
  localparam logic [DRY_TOL_W-1:0] DRY_TOL_RST = 16'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_DRY_TOL = 2'd1
  } cfg_reg_t;

  function automatic val_t clampv(input logic signed [VAL_W:0] s);
    if (s > LIM) return LIM;
    if (s < NLIM) return NLIM;
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t addv(input val_t a, input val_t b);
    return clampv({a[VAL_W-1], a} + {b[VAL_W-1], b});
  endfunction

  function automatic val_t subv(input val_t a, input val_t b);
    return clampv({a[VAL_W-1], a} - {b[VAL_W-1], b});
  endfunction

  function automatic val_t halfv(input val_t x);
    return x[VAL_W-1] ? -((-x) >>> 1) : (x >>> 1);
  endfunction

  function automatic val_t quarterv(input val_t x);
    return x[VAL_W-1] ? -((-x) >>> 2) : (x >>> 2);
  endfunction

  function automatic logic [MAG_W-1:0] magv(input val_t x);
    val_t m;
    m = x[VAL_W-1] ? -x : x;
    return m[MAG_W-1:0];
  endfunction

endpackage

### rtl/hfsw_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one cell interface state.
// ----------------------------------------------------------------------------
interface hfsw_in_if;
  logic               valid;
  logic               ready;
  logic        [30:0] depth_west;
  logic        [30:0] depth_east;
  logic signed [31:0] discharge_west;
  logic signed [31:0] discharge_east;
  logic               last_interface;

  modport source (output valid, depth_west, depth_east, discharge_west, discharge_east,
                  last_interface, input ready);
  modport sink   (input valid, depth_west, depth_east, discharge_west, discharge_east,
                  last_interface, output ready);
endinterface

### rtl/hfsw_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying the mass and momentum flux of one interface.
// ----------------------------------------------------------------------------
interface hfsw_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] mass_flux;
  logic signed [DATA_WIDTH-1:0] momentum_flux;
  logic                         last_out;

  modport source (output valid, mass_flux, momentum_flux, last_out, input ready);
  modport sink   (input valid, mass_flux, momentum_flux, last_out, output ready);
endinterface

### rtl/hfsw_dly.sv
// ----------------------------------------------------------------------------
// Enabled delay line
// Shift register that aligns side data with the arithmetic units.
// ----------------------------------------------------------------------------
module hfsw_dly #(
  parameter int W   = 1,
  parameter int N   = 1,
  parameter bit CLR = 1'b0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (N == 0) begin : g_pass
      assign q = d;
    end else begin : g_sr
      logic [W-1:0] sr_r [0:N-1];
      always_ff @(posedge clk) begin
        if (CLR && !rst_n) begin
          for (int i = 0; i < N; i++) sr_r[i] <= '0;
        end else if (en) begin
          sr_r[0] <= d;
          for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
        end
      end
      assign q = sr_r[N-1];
    end
  endgenerate

endmodule

### rtl/hfsw_mul.sv
// ----------------------------------------------------------------------------
// Fixed point multiplier
// Four stage signed magnitude multiply built from 31x31 partial products.
// ----------------------------------------------------------------------------
module hfsw_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  hfsw_pkg::val_t a,
  input  hfsw_pkg::val_t b,
  output hfsw_pkg::val_t p
);
  import hfsw_pkg::*;

  localparam int HW = MAG_W / 2;
  localparam int PW = 2 * MAG_W;

  logic [MAG_W-1:0] ma_r, mb_r;
  logic             neg1_r, neg2_r, neg3_r;
  logic [2*HW-1:0]  pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    sh;
  logic [2*HW:0]    mid;
  val_t             mg;
  val_t             p_r;

  assign mid = {1'b0, pp_hl_r} + {1'b0, pp_lh_r};
  assign sh  = prod_r >> FRAC_BITS;
  assign mg  = (sh > PW'(LIM_MAG)) ? LIM : val_t'(sh[VAL_W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r    <= magv(a);
      mb_r    <= magv(b);
      neg1_r  <= a[VAL_W-1] ^ b[VAL_W-1];
      pp_hh_r <= ma_r[MAG_W-1:HW] * mb_r[MAG_W-1:HW];
      pp_hl_r <= ma_r[MAG_W-1:HW] * mb_r[HW-1:0];
      pp_lh_r <= ma_r[HW-1:0] * mb_r[MAG_W-1:HW];
      pp_ll_r <= ma_r[HW-1:0] * mb_r[HW-1:0];
      neg2_r  <= neg1_r;
      prod_r  <= (PW'(pp_hh_r) << (2*HW)) + (PW'(mid) << HW) + PW'(pp_ll_r);
      neg3_r  <= neg2_r;
      p_r     <= neg3_r ? -mg : mg;
    end
  end

  assign p = p_r;

endmodule

### rtl/hfsw_div.sv
// ----------------------------------------------------------------------------
// Fixed point divider
// Restoring divider, one quotient bit per pipeline stage, saturating result.
// ----------------------------------------------------------------------------
module hfsw_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  hfsw_pkg::val_t num,
  input  hfsw_pkg::val_t den,
  output hfsw_pkg::val_t q
);
  import hfsw_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;

  logic [NW-1:0]    nn_r  [0:NW];
  logic [NW-1:0]    qq_r  [0:NW];
  logic [MAG_W-1:0] rem_r [0:NW];
  logic [MAG_W-1:0] dd_r  [0:NW];
  logic             neg_r [0:NW];
  logic             dz_r  [0:NW];
  val_t             qm;
  val_t             q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r[0]  <= {magv(num), {FRAC_BITS{1'b0}}};
      qq_r[0]  <= '0;
      rem_r[0] <= '0;
      dd_r[0]  <= magv(den);
      neg_r[0] <= num[VAL_W-1] ^ den[VAL_W-1];
      dz_r[0]  <= (den == '0);
    end
  end

  genvar k;
  generate
    for (k = 1; k <= NW; k++) begin : g_stage
      localparam int I = NW - k;
      logic [MAG_W:0] trial;
      logic           ge;
      assign trial = {rem_r[k-1], nn_r[k-1][I]};
      assign ge    = trial >= {1'b0, dd_r[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? MAG_W'(trial - {1'b0, dd_r[k-1]}) : trial[MAG_W-1:0];
          qq_r[k]  <= qq_r[k-1] | (NW'(ge) << I);
          nn_r[k]  <= nn_r[k-1];
          dd_r[k]  <= dd_r[k-1];
          neg_r[k] <= neg_r[k-1];
          dz_r[k]  <= dz_r[k-1];
        end
      end
    end
  endgenerate

  assign qm = (qq_r[NW] > NW'(LIM_MAG)) ? LIM : val_t'(qq_r[NW][VAL_W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= dz_r[NW] ? '0 : (neg_r[NW] ? -qm : qm);
    end
  end

  assign q = q_r;

endmodule

### rtl/hfsw_sqrt.sv
// ----------------------------------------------------------------------------
// Fixed point square root
// Digit by digit integer root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module hfsw_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  hfsw_pkg::val_t x,
  output hfsw_pkg::val_t r
);
  import hfsw_pkg::*;

  localparam int XW = MAG_W + FRAC_BITS;
  localparam int RB = (XW + 1) / 2;

  logic [2*RB-1:0] x_r    [0:RB];
  logic [RB+1:0]   rem_r  [0:RB];
  logic [RB-1:0]   root_r [0:RB];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= (x <= 0) ? '0 : (2*RB)'({x[MAG_W-1:0], {FRAC_BITS{1'b0}}});
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= RB; k++) begin : g_stage
      localparam int SH = 2 * (RB - k);
      logic [RB+3:0] trial;
      logic [RB+3:0] tst;
      logic          ge;
      assign trial = {rem_r[k-1], x_r[k-1][SH+1:SH]};
      assign tst   = {2'b00, root_r[k-1], 2'b01};
      assign ge    = trial >= tst;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? (RB+2)'(trial - tst) : trial[RB+1:0];
          root_r[k] <= {root_r[k-1][RB-2:0], ge};
          x_r[k]    <= x_r[k-1];
        end
      end
    end
  endgenerate

  assign r = val_t'(root_r[RB]);

endmodule

### rtl/hll_flux_shallow_water.sv
// ----------------------------------------------------------------------------
// HLL flux for 1D shallow water
// Streams one cell interface per transaction and returns its mass and
// momentum flux, fully pipelined in fixed point.
//
//   Channel  Direction  Payload
//   in_ch    sink       depths, discharges, last_interface
//   out_ch   source     mass_flux, momentum_flux, last_out
//   cfg_*    write      gravity (index 0), dry_tolerance (index 1)
//
// One transaction is accepted per cycle while the pipeline enable is high. The
// path from an accepted input to its result runs through the three chained
// dividers, one square root, four multipliers and six add or output stages.
// The whole pipeline advances on one enable that holds while the output
// register is full and not taken. Reset clears the valid bits and restores
// the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hll_flux_shallow_water #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hfsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  hfsw_in_if.sink                         in_ch,
  hfsw_out_if.source                      out_ch
);
  import hfsw_pkg::*;

  localparam int LM = MUL_LAT;
  localparam int LD = MAG_W + FRAC_BITS + 2;
  localparam int LS = (MAG_W + FRAC_BITS + 1) / 2 + 1;
  localparam int T1 = LD;
  localparam int TA = T1 + 2 + 2*LM + LD + LS;
  localparam int TS = TA + 2;
  localparam int TB = TS + 2*LM + 1;
  localparam int TF = TB + LD;
  localparam val_t OUT_MAX = {{(VAL_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam val_t OUT_MIN = ~OUT_MAX;

  logic [GRAVITY_W-1:0] gravity_r;
  logic [DRY_TOL_W-1:0] dry_tol_r;
  logic                 en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RST;
      dry_tol_r <= DRY_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY: gravity_r <= cfg_wdata[GRAVITY_W-1:0];
        CFG_DRY_TOL: dry_tol_r <= cfg_wdata[DRY_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  val_t g0, hw0, he0, qw0, qe0, dh0, dq0;
  logic dw0, de0;

  assign g0  = val_t'(gravity_r);
  assign hw0 = val_t'(in_ch.depth_west);
  assign he0 = val_t'(in_ch.depth_east);
  assign qw0 = val_t'(in_ch.discharge_west);
  assign qe0 = val_t'(in_ch.discharge_east);
  assign dw0 = in_ch.depth_west <= DEPTH_W'(dry_tol_r);
  assign de0 = in_ch.depth_east <= DEPTH_W'(dry_tol_r);
  assign dh0 = subv(he0, hw0);
  assign dq0 = subv(qe0, qw0);

  // Velocities, celerities and hydrostatic terms.
  val_t uw_raw, ue_raw, ghw, ghe, aw_raw, ae_raw, hhw, hhe, ghhw, ghhe;

  hfsw_div  #(.FRAC_BITS(FRAC_BITS)) u_div_uw (.clk, .en, .num(qw0), .den(hw0), .q(uw_raw));
  hfsw_div  #(.FRAC_BITS(FRAC_BITS)) u_div_ue (.clk, .en, .num(qe0), .den(he0), .q(ue_raw));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_gw (.clk, .en, .a(g0), .b(hw0), .p(ghw));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_ge (.clk, .en, .a(g0), .b(he0), .p(ghe));
  hfsw_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_aw (.clk, .en, .x(ghw), .r(aw_raw));
  hfsw_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_ae (.clk, .en, .x(ghe), .r(ae_raw));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_hhw (.clk, .en, .a(hw0), .b(hw0), .p(hhw));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_hhe (.clk, .en, .a(he0), .b(he0), .p(hhe));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_ghhw (.clk, .en, .a(g0), .b(hhw), .p(ghhw));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_ghhe (.clk, .en, .a(g0), .b(hhe), .p(ghhe));

  logic [1:0]         dry_t1;
  logic [2*VAL_W-1:0] a_t1, q_t1;
  val_t               aw1, ae1, qw1, qe1, uw1, ue1;

  hfsw_dly #(.W(2), .N(LD)) u_dly_dry1 (.clk, .rst_n, .en, .d({dw0, de0}), .q(dry_t1));
  hfsw_dly #(.W(2*VAL_W), .N(LD-LM-LS)) u_dly_a1 (.clk, .rst_n, .en,
                                                   .d({aw_raw, ae_raw}), .q(a_t1));
  hfsw_dly #(.W(2*VAL_W), .N(LD)) u_dly_q1 (.clk, .rst_n, .en, .d({qw0, qe0}), .q(q_t1));

  assign {aw1, ae1} = a_t1;
  assign {qw1, qe1} = q_t1;
  assign uw1 = dry_t1[1] ? '0 : uw_raw;
  assign ue1 = dry_t1[0] ? '0 : ue_raw;

  // Star state estimate.
  val_t sa_r, du_r, su_r, aw2_r, ae2_r, ae3_r, base_r, us1_r, us_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r   <= addv(aw1, ae1);
      du_r   <= subv(uw1, ue1);
      su_r   <= addv(uw1, ue1);
      aw2_r  <= aw1;
      ae2_r  <= ae1;
      base_r <= addv(halfv(sa_r), quarterv(du_r));
      us1_r  <= addv(halfv(su_r), aw2_r);
      ae3_r  <= ae2_r;
      us_r   <= subv(us1_r, ae3_r);
    end
  end

  val_t uqw, uqe, ghhw_d, ghhe_d, momw_r, mome_r;

  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uqw (.clk, .en, .a(uw1), .b(qw1), .p(uqw));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uqe (.clk, .en, .a(ue1), .b(qe1), .p(uqe));
  hfsw_dly #(.W(VAL_W), .N(LD-LM)) u_dly_ghhw (.clk, .rst_n, .en, .d(ghhw), .q(ghhw_d));
  hfsw_dly #(.W(VAL_W), .N(LD-LM)) u_dly_ghhe (.clk, .rst_n, .en, .d(ghhe), .q(ghhe_d));

  always_ff @(posedge clk) begin
    if (en) begin
      momw_r <= addv(uqw, halfv(ghhw_d));
      mome_r <= addv(uqe, halfv(ghhe_d));
    end
  end

  val_t bb, hs, ghs, as_raw;

  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (.clk, .en, .a(base_r), .b(base_r), .p(bb));
  hfsw_div  #(.FRAC_BITS(FRAC_BITS)) u_div_hs (.clk, .en, .num(bb), .den(g0), .q(hs));
  hfsw_mul  #(.FRAC_BITS(FRAC_BITS)) u_mul_ghs (.clk, .en, .a(g0), .b(hs), .p(ghs));
  hfsw_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_as (.clk, .en, .x(ghs), .r(as_raw));

  logic [4*VAL_W-1:0] ua_ta;
  logic [1:0]         dry_ta;
  val_t               uw_a, ue_a, aw_a, ae_a, us_a;

  hfsw_dly #(.W(4*VAL_W), .N(TA-T1)) u_dly_ua (.clk, .rst_n, .en,
                                              .d({uw1, ue1, aw1, ae1}), .q(ua_ta));
  hfsw_dly #(.W(2), .N(TA-T1)) u_dly_dry2 (.clk, .rst_n, .en, .d(dry_t1), .q(dry_ta));
  hfsw_dly #(.W(VAL_W), .N(TA-T1-3)) u_dly_us (.clk, .rst_n, .en, .d(us_r), .q(us_a));

  assign {uw_a, ue_a, aw_a, ae_a} = ua_ta;

  // Wave speed bounds.
  val_t tw1_r, tw2_r, te1_r, te2_r, a2w_r, a2e_r, uwx_r, uex_r, sw_r, se_r;
  logic [1:0] dryx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tw1_r  <= subv(uw_a, aw_a);
      tw2_r  <= subv(us_a, as_raw);
      te1_r  <= addv(ue_a, ae_a);
      te2_r  <= addv(us_a, as_raw);
      a2w_r  <= addv(aw_a, aw_a);
      a2e_r  <= addv(ae_a, ae_a);
      uwx_r  <= uw_a;
      uex_r  <= ue_a;
      dryx_r <= dry_ta;
      sw_r   <= dryx_r[1] ? subv(uex_r, a2e_r) : ((tw1_r < tw2_r) ? tw1_r : tw2_r);
      se_r   <= dryx_r[0] ? addv(uwx_r, a2w_r) : ((te1_r > te2_r) ? te1_r : te2_r);
    end
  end

  // HLL blend.
  logic [2*VAL_W-1:0] q_ts, m_ts, dhq_t;
  val_t qw_s, qe_s, mw_s, me_s, dh_s, dq_s;

  hfsw_dly #(.W(2*VAL_W), .N(TS-T1)) u_dly_q2 (.clk, .rst_n, .en, .d(q_t1), .q(q_ts));
  hfsw_dly #(.W(2*VAL_W), .N(TS-T1-LM-1)) u_dly_m (.clk, .rst_n, .en,
                                                   .d({momw_r, mome_r}), .q(m_ts));
  hfsw_dly #(.W(2*VAL_W), .N(TS+LM)) u_dly_dhq (.clk, .rst_n, .en,
                                               .d({dh0, dq0}), .q(dhq_t));

  assign {qw_s, qe_s} = q_ts;
  assign {mw_s, me_s} = m_ts;
  assign {dh_s, dq_s} = dhq_t;

  val_t ss, p1, p2, p3, p4, m5, m6, d1_r, d2_r, d1_d, d2_d, nm_r, np_r, den_b;

  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ss (.clk, .en, .a(sw_r), .b(se_r), .p(ss));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1 (.clk, .en, .a(se_r), .b(qw_s), .p(p1));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2 (.clk, .en, .a(sw_r), .b(qe_s), .p(p2));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p3 (.clk, .en, .a(se_r), .b(mw_s), .p(p3));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p4 (.clk, .en, .a(sw_r), .b(me_s), .p(p4));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m5 (.clk, .en, .a(ss), .b(dh_s), .p(m5));
  hfsw_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m6 (.clk, .en, .a(ss), .b(dq_s), .p(m6));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= subv(p1, p2);
      d2_r <= subv(p3, p4);
      nm_r <= addv(d1_d, m5);
      np_r <= addv(d2_d, m6);
    end
  end

  hfsw_dly #(.W(VAL_W), .N(LM-1)) u_dly_d1 (.clk, .rst_n, .en, .d(d1_r), .q(d1_d));
  hfsw_dly #(.W(VAL_W), .N(LM-1)) u_dly_d2 (.clk, .rst_n, .en, .d(d2_r), .q(d2_d));
  hfsw_dly #(.W(VAL_W), .N(2*LM+1)) u_dly_den (.clk, .rst_n, .en,
                                              .d(subv(se_r, sw_r)), .q(den_b));

  val_t mf_div, pf_div;

  hfsw_div #(.FRAC_BITS(FRAC_BITS)) u_div_mf (.clk, .en, .num(nm_r), .den(den_b), .q(mf_div));
  hfsw_div #(.FRAC_BITS(FRAC_BITS)) u_div_pf (.clk, .en, .num(np_r), .den(den_b), .q(pf_div));

  // Side data aligned with the final dividers.
  logic [1:0]         sgn_f, dl_f;
  logic [4*VAL_W-1:0] qm_f;
  logic               vld_f;
  val_t               qw_f, qe_f, mw_f, me_f;

  hfsw_dly #(.W(2), .N(TF-TS)) u_dly_sgn (.clk, .rst_n, .en,
                                         .d({~sw_r[VAL_W-1], ~se_r[VAL_W-1]}), .q(sgn_f));
  hfsw_dly #(.W(4*VAL_W), .N(TF-TS)) u_dly_qm (.clk, .rst_n, .en,
                                              .d({qw_s, qe_s, mw_s, me_s}), .q(qm_f));
  hfsw_dly #(.W(2), .N(TF)) u_dly_dl (.clk, .rst_n, .en,
                                     .d({dw0 & de0, in_ch.last_interface}), .q(dl_f));
  hfsw_dly #(.W(1), .N(TF), .CLR(1'b1)) u_dly_vld (.clk, .rst_n, .en,
                                                   .d(in_ch.valid), .q(vld_f));

  assign {qw_f, qe_f, mw_f, me_f} = qm_f;

  val_t mf_sel, pf_sel, mf_sat, pf_sat;

  always_comb begin
    if (dl_f[1]) begin
      mf_sel = '0;
      pf_sel = '0;
    end else if (sgn_f[1]) begin
      mf_sel = qw_f;
      pf_sel = mw_f;
    end else if (sgn_f[0]) begin
      mf_sel = mf_div;
      pf_sel = pf_div;
    end else begin
      mf_sel = qe_f;
      pf_sel = me_f;
    end
    mf_sat = (mf_sel > OUT_MAX) ? OUT_MAX : ((mf_sel < OUT_MIN) ? OUT_MIN : mf_sel);
    pf_sat = (pf_sel > OUT_MAX) ? OUT_MAX : ((pf_sel < OUT_MIN) ? OUT_MIN : pf_sel);
  end

  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] mass_flux_r, momentum_flux_r;
  logic                         last_r, dry_out_r;

  assign en = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mass_flux_r     <= mf_sat[DATA_WIDTH-1:0];
      momentum_flux_r <= pf_sat[DATA_WIDTH-1:0];
      last_r          <= dl_f[0];
      dry_out_r       <= dl_f[1];
    end
  end

  assign in_ch.ready          = en;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.mass_flux     = mass_flux_r;
  assign out_ch.momentum_flux = momentum_flux_r;
  assign out_ch.last_out      = last_r;

  `ASSERT_NEXT(a_rst_no_valid, clk, 1'b1, !rst_n, !out_valid_r)
  `ASSERT_IMPL(a_dry_zero, clk, rst_n, out_valid_r && dry_out_r, mass_flux_r == '0 && momentum_flux_r == '0)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(vld_f))

endmodule
